FILE: rtl/core/lpbm_pkg.sv
`default_nettype none

package lpbm_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int TABLE_W    = 10;
  localparam int PAGE_W     = 32;
  localparam int OUT_IDX_W  = 4;

  localparam logic [FRAME_W-1:0] TAIL_RANK = FRAME_W'(NUM_FRAMES - 1);

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic                is_write;
    logic [TABLE_W-1:0]  tbl;
    logic [PAGE_W-1:0]   pg;
  } req_t;

  typedef enum logic {
    BK_LOOK,
    BK_APPLY
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lpbm_front.sv
`default_nettype none

module lpbm_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_func,
  input  wire logic [lpbm_pkg::TABLE_W-1:0] in_table,
  input  wire logic [lpbm_pkg::PAGE_W-1:0]  in_page,
  output logic                              q_valid,
  output lpbm_pkg::req_t                    q_req,
  input  wire logic                         q_pop
);

  lpbm_pkg::req_t                      mem_r [lpbm_pkg::Q_DEPTH];
  logic [lpbm_pkg::Q_PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [lpbm_pkg::Q_PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [lpbm_pkg::Q_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                                push;
  logic                                pop;
  lpbm_pkg::req_t                      new_req;

  assign busy    = (cnt_r == lpbm_pkg::Q_CNT_W'(lpbm_pkg::Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_req   = mem_r[rd_ptr_r];

  // classify the request kind
  always_comb begin
    new_req.is_write = (in_func == lpbm_pkg::FUNC_WRITE);
    new_req.tbl      = in_table;
    new_req.pg       = in_page;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpbm_back.sv
`default_nettype none

module lpbm_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire lpbm_pkg::req_t                 q_req,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [lpbm_pkg::OUT_IDX_W-1:0]      out_frame_index,
  output logic                                out_writeback_valid,
  output logic [lpbm_pkg::TABLE_W-1:0]        out_writeback_table,
  output logic [lpbm_pkg::PAGE_W-1:0]         out_writeback_page,
  output logic                                out_fetch_valid
);

  localparam int NF = lpbm_pkg::NUM_FRAMES;
  localparam int FW = lpbm_pkg::FRAME_W;

  lpbm_pkg::back_state_t          state_r, state_nxt;

  logic                           valid_r [NF];
  logic                           dirty_r [NF];
  logic [FW-1:0]                  rank_r  [NF];
  logic [lpbm_pkg::TABLE_W-1:0]   table_r [NF];
  logic [lpbm_pkg::PAGE_W-1:0]    page_r  [NF];

  lpbm_pkg::req_t                 req_r;
  logic                           hit_r;
  logic [FW-1:0]                  idx_r;

  logic                           look;
  logic                           apply;
  logic                           any_hit;
  logic [FW-1:0]                  hit_idx;
  logic [FW-1:0]                  tail_idx;
  logic                           wb;
  logic [FW-1:0]                  cur_rank;
  logic [FW+lpbm_pkg::OUT_IDX_W-1:0] idx_ext;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [lpbm_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic                           out_wb_r;
  logic [lpbm_pkg::TABLE_W-1:0]   out_wb_table_r;
  logic [lpbm_pkg::PAGE_W-1:0]    out_wb_page_r;
  logic                           out_fetch_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpbm_pkg::BK_LOOK:  if (q_valid) state_nxt = lpbm_pkg::BK_APPLY;
      lpbm_pkg::BK_APPLY: state_nxt = lpbm_pkg::BK_LOOK;
      default:            state_nxt = lpbm_pkg::BK_LOOK;
    endcase
  end

  // state outputs
  always_comb begin
    look  = 1'b0;
    apply = 1'b0;
    unique case (state_r)
      lpbm_pkg::BK_LOOK:  look  = q_valid;
      lpbm_pkg::BK_APPLY: apply = 1'b1;
      default:            ;
    endcase
  end

  assign q_pop = look;

  // parallel tag compare; at most one frame matches, tail rank is unique
  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    tail_idx = '0;
    for (int i = 0; i < NF; i++) begin
      if (valid_r[i] && table_r[i] == q_req.tbl && page_r[i] == q_req.pg) begin
        any_hit = 1'b1;
        hit_idx = hit_idx | FW'(i);
      end
      if (rank_r[i] == lpbm_pkg::TAIL_RANK) begin
        tail_idx = tail_idx | FW'(i);
      end
    end
  end

  assign wb       = !hit_r && valid_r[idx_r] && dirty_r[idx_r];
  assign cur_rank = rank_r[idx_r];
  assign idx_ext  = {{lpbm_pkg::OUT_IDX_W{1'b0}}, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpbm_pkg::BK_LOOK;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        valid_r[i] <= 1'b0;
        dirty_r[i] <= 1'b0;
        rank_r[i]  <= FW'(i);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= apply;
      if (apply) begin
        if (!hit_r) begin
          valid_r[idx_r] <= 1'b1;
        end
        if (req_r.is_write) begin
          dirty_r[idx_r] <= 1'b1;
        end else begin
          if (!hit_r) begin
            dirty_r[idx_r] <= 1'b0;
          end
          // move to head: everything younger than the frame ages by one
          for (int i = 0; i < NF; i++) begin
            if (FW'(i) == idx_r) begin
              rank_r[i] <= '0;
            end else if (rank_r[i] < cur_rank) begin
              rank_r[i] <= rank_r[i] + 1'b1;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (look) begin
      req_r <= q_req;
      hit_r <= any_hit;
      idx_r <= any_hit ? hit_idx : tail_idx;
    end
    if (apply) begin
      if (!hit_r) begin
        table_r[idx_r] <= req_r.tbl;
        page_r[idx_r]  <= req_r.pg;
      end
      out_hit_r      <= hit_r;
      out_idx_r      <= idx_ext[lpbm_pkg::OUT_IDX_W-1:0];
      out_wb_r       <= wb;
      out_wb_table_r <= wb ? table_r[idx_r] : '0;
      out_wb_page_r  <= wb ? page_r[idx_r] : '0;
      out_fetch_r    <= !hit_r && !req_r.is_write;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_frame_index     = out_idx_r;
  assign out_writeback_valid = out_wb_r;
  assign out_writeback_table = out_wb_table_r;
  assign out_writeback_page  = out_wb_page_r;
  assign out_fetch_valid     = out_fetch_r;

endmodule

`default_nettype wire

FILE: rtl/core/lru_page_buffer_manager_unit.sv
`default_nettype none

// Channel   Handshake                 Payload
// --------  ------------------------  -------------------------------------------------
// request   start / busy              in_func, in_table, in_page
// result    out_valid (one cycle)     out_hit, out_frame_index, out_writeback_valid,
//                                     out_writeback_table, out_writeback_page,
//                                     out_fetch_valid
//
// An item is taken when start is high and busy is low; it lands in a two-entry
// request queue. The back end handles each item in state BK_LOOK (tag compare
// of all frames), then in BK_APPLY (tag/dirty update, and recency update on
// reads), and pops the next item only after BK_APPLY. The result is registered
// out of BK_APPLY. busy rises only while the queue is full. Reset (rst_n low,
// synchronous) empties the queue, marks all frames empty and clean, and sets
// frame i to recency rank i. The receiver cannot stall: each result is on the
// ports for exactly one cycle with out_valid high.

module lru_page_buffer_manager_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_func,
  input  wire logic [lpbm_pkg::TABLE_W-1:0]   in_table,
  input  wire logic [lpbm_pkg::PAGE_W-1:0]    in_page,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [lpbm_pkg::OUT_IDX_W-1:0]      out_frame_index,
  output logic                                out_writeback_valid,
  output logic [lpbm_pkg::TABLE_W-1:0]        out_writeback_table,
  output logic [lpbm_pkg::PAGE_W-1:0]         out_writeback_page,
  output logic                                out_fetch_valid
);

  // queue hand-off between front and back
  logic           q_valid;
  logic           q_pop;
  lpbm_pkg::req_t q_req;

  // front: accept, decode the request kind, hold in queue
  lpbm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_table    (in_table),
    .in_page     (in_page),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop)
  );

  // back: look up the frame, pick hit or victim, update state, drive result
  lpbm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_req               (q_req),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_frame_index     (out_frame_index),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_table (out_writeback_table),
    .out_writeback_page  (out_writeback_page),
    .out_fetch_valid     (out_fetch_valid)
  );

endmodule

`default_nettype wire
